/* rtl/core/rrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types and byte codes for the request parser.
// ----------------------------------------------------------------------------
package rrp_pkg;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_START    = 3'd1;
  localparam logic [2:0] KIND_EMPTY    = 3'd2;
  localparam logic [2:0] KIND_LEN_ERR  = 3'd3;
  localparam logic [2:0] KIND_TOO_MANY = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [3:0]  arg_index;
    logic [31:0] element_count;
    logic        last_in_arg;
    logic        last_in_request;
  } result_t;

endpackage

/* rtl/core/resp_request_parser.sv */
`timescale 1ns / 1ps
// An accepted byte passes the input register and then the result buffer before its result can be taken.
// Throughput: one byte per cycle, set by the phase update, unless the result buffer is full;
// a two-entry result buffer keeps input flowing while a result waits.
// Bytes that give no result are absorbed after the input register.
// Reset (rst, synchronous): parser returns to the type-byte phase, counters
// clear, input register and result buffer empty.
// ----------------------------------------------------------------------------
// resp_request_parser
// Byte-serial request tracker emitting payload bytes and request events.
// ----------------------------------------------------------------------------
module resp_request_parser #(
  parameter int MAX_ARGS     = 16,
  parameter int LENGTH_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  data_byte,
  output logic [3:0]  arg_index,
  output logic [31:0] element_count,
  output logic        last_in_arg,
  output logic        last_in_request
);
  import rrp_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_reg;
  logic       adv;
  logic       buf_room;
  logic       res_valid;
  result_t    res;
  result_t    dout;

  assign adv      = byte_valid && buf_room;
  assign in_ready = !byte_valid || buf_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= stream_byte;
    end
  end

  rrp_parser #(
    .MAX_ARGS     (MAX_ARGS),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .byte_in   (byte_reg),
    .res_valid (res_valid),
    .res       (res)
  );

  rrp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (adv && res_valid),
    .din       (res),
    .has_room  (buf_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  assign kind            = dout.kind;
  assign data_byte       = dout.data_byte;
  assign arg_index       = dout.arg_index;
  assign element_count   = dout.element_count;
  assign last_in_arg     = dout.last_in_arg;
  assign last_in_request = dout.last_in_request;

endmodule

/* rtl/core/rrp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_parser
// Phase machine and counters; one registered byte in, at most one result out.
// ----------------------------------------------------------------------------
module rrp_parser #(
  parameter int MAX_ARGS     = 16,
  parameter int LENGTH_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_in,
  output logic             res_valid,
  output rrp_pkg::result_t res
);
  import rrp_pkg::*;

  localparam int CUR_W = $clog2(MAX_ARGS + 1);
  localparam int ACC_W = LENGTH_WIDTH + 4;

  typedef enum logic [5:0] {
    PH_TYPE     = 6'b000001,
    PH_LEN      = 6'b000010,
    PH_LF       = 6'b000100,
    PH_PAYLOAD  = 6'b001000,
    PH_TRAIL_CR = 6'b010000,
    PH_TRAIL_LF = 6'b100000
  } phase_t;

  phase_t                  phase, phase_next;
  logic                    hdr_array, hdr_array_next;
  logic [LENGTH_WIDTH-1:0] acc, acc_next;
  logic [LENGTH_WIDTH-1:0] pay_rem, pay_rem_next;
  logic [LENGTH_WIDTH-1:0] elem_rem, elem_rem_next;
  logic [CUR_W-1:0]        cur, cur_next;

  logic [ACC_W-1:0]        acc_x10;
  logic                    is_digit;
  logic                    overflow;
  logic                    lir;
  logic                    pay_last;
  logic [LENGTH_WIDTH-1:0] elem_dec;
  logic [CUR_W-1:0]        cur_inc;

  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign acc_x10  = (ACC_W'(acc) << 3) + (ACC_W'(acc) << 1) + ACC_W'(byte_in[3:0]);
  assign overflow = |acc_x10[ACC_W-1:LENGTH_WIDTH];
  assign lir      = (elem_rem <= LENGTH_WIDTH'(1));
  assign pay_last = (pay_rem <= LENGTH_WIDTH'(1));
  assign elem_dec = (elem_rem != '0) ? elem_rem - LENGTH_WIDTH'(1) : elem_rem;
  assign cur_inc  = (cur < CUR_W'(MAX_ARGS)) ? cur + CUR_W'(1) : cur;

  always_comb begin
    phase_next     = phase;
    hdr_array_next = hdr_array;
    acc_next       = acc;
    pay_rem_next   = pay_rem;
    elem_rem_next  = elem_rem;
    cur_next       = cur;
    res_valid      = 1'b0;
    res            = '0;
    unique case (phase)
      PH_TYPE: begin
        if (byte_in == CH_STAR || byte_in == CH_DOLLAR) begin
          hdr_array_next = (byte_in == CH_STAR);
          acc_next       = '0;
          phase_next     = PH_LEN;
        end
      end
      PH_LEN: begin
        if (is_digit && !overflow) begin
          acc_next = acc_x10[LENGTH_WIDTH-1:0];
        end else if (is_digit || byte_in != CH_CR) begin
          elem_rem_next = '0;
          cur_next      = '0;
          acc_next      = '0;
          phase_next    = PH_TYPE;
          res_valid     = 1'b1;
          res.kind      = KIND_LEN_ERR;
        end else if (hdr_array) begin
          elem_rem_next     = acc;
          cur_next          = '0;
          phase_next        = PH_LF;
          res_valid         = 1'b1;
          res.kind          = KIND_START;
          res.element_count = 32'(acc);
        end else if (cur >= CUR_W'(MAX_ARGS)) begin
          elem_rem_next = '0;
          cur_next      = '0;
          acc_next      = '0;
          phase_next    = PH_TYPE;
          res_valid     = 1'b1;
          res.kind      = KIND_TOO_MANY;
          res.arg_index = 4'(cur);
        end else begin
          pay_rem_next = acc;
          phase_next   = PH_LF;
          if (acc == '0) begin
            res_valid           = 1'b1;
            res.kind            = KIND_EMPTY;
            res.arg_index       = 4'(cur);
            res.last_in_arg     = 1'b1;
            res.last_in_request = lir;
            elem_rem_next       = elem_dec;
            cur_next            = cur_inc;
          end
        end
      end
      PH_LF: begin
        if (hdr_array) begin
          phase_next = PH_TYPE;
        end else if (pay_rem == '0) begin
          phase_next = PH_TRAIL_CR;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid           = 1'b1;
        res.kind            = KIND_PAYLOAD;
        res.data_byte       = byte_in;
        res.arg_index       = 4'(cur);
        res.last_in_arg     = pay_last;
        res.last_in_request = lir;
        if (pay_last) begin
          pay_rem_next  = '0;
          elem_rem_next = elem_dec;
          cur_next      = cur_inc;
          phase_next    = PH_TRAIL_CR;
        end else begin
          pay_rem_next = pay_rem - LENGTH_WIDTH'(1);
        end
      end
      PH_TRAIL_CR: phase_next = PH_TRAIL_LF;
      PH_TRAIL_LF: phase_next = PH_TYPE;
      default:     phase_next = PH_TYPE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TYPE;
      hdr_array <= 1'b0;
      acc       <= '0;
      pay_rem   <= '0;
      elem_rem  <= '0;
      cur       <= '0;
    end else if (step) begin
      phase     <= phase_next;
      hdr_array <= hdr_array_next;
      acc       <= acc_next;
      pay_rem   <= pay_rem_next;
      elem_rem  <= elem_rem_next;
      cur       <= cur_next;
    end
  end

endmodule

/* rtl/core/rrp_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_out_buf
// Two-entry result buffer; decouples the parser from the output handshake.
// ----------------------------------------------------------------------------
module rrp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrp_pkg::result_t din,
  output logic             has_room,
  output logic             out_valid,
  input  logic             out_ready,
  output rrp_pkg::result_t dout
);
  import rrp_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign has_room  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign dout      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/rrp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_checker
// Port-level checks on the result stream of the request parser.
// ----------------------------------------------------------------------------
module rrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [7:0]  data_byte,
  input logic [3:0]  arg_index,
  input logic [31:0] element_count,
  input logic        last_in_arg,
  input logic        last_in_request
);
  import rrp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte)
      && $stable(arg_index) && $stable(element_count))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == KIND_PAYLOAD || kind == KIND_START || kind == KIND_EMPTY
      || kind == KIND_LEN_ERR || kind == KIND_TOO_MANY)
    else $error("undefined result kind");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PAYLOAD |-> data_byte == 8'd0)
    else $error("data byte set outside payload item");

  a_start_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_START |-> arg_index == 4'd0 && !last_in_arg
      && !last_in_request)
    else $error("request start carries argument fields");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EMPTY |-> last_in_arg && element_count == 32'd0)
    else $error("empty argument item malformed");

endmodule

bind resp_request_parser rrp_checker u_rrp_checker (.*);

/* dv/tb_resp_request_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resp_request_parser
// Feeds the request parser with whole requests, stray and broken headers and
// noise, one byte per item, with random idling on both sides. Every accepted
// byte runs through a local parser model; the results it predicts are checked
// field by field, in order, against the results the block hands out.
// ----------------------------------------------------------------------------
module tb_resp_request_parser;
  import rrp_pkg::*;

  localparam int          MAX_ARGS     = 16;
  localparam int          LENGTH_WIDTH = 32;
  localparam longint unsigned LEN_LIMIT = (64'd1 << LENGTH_WIDTH) - 1;
  localparam logic [7:0]  CH_LF        = 8'h0A;
  localparam int          STREAM_BYTES = 750;
  localparam int          CALM_TAIL    = 60;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          TAIL_CYCLES  = 20;

  typedef enum logic [2:0] {
    P_TYPE, P_LEN, P_LF, P_PAYLOAD, P_TRAIL_CR, P_TRAIL_LF
  } parse_phase_t;

  typedef enum logic [1:0] {OP_BYTE, OP_DRAIN, OP_HOLD} feed_op_t;

  typedef struct {
    feed_op_t   op;
    logic [7:0] val;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  stream_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [3:0]  arg_index;
  logic [31:0] element_count;
  logic        last_in_arg;
  logic        last_in_request;

  feed_t   feed_q[$];
  result_t parsed_q[$];
  result_t seen_res;
  result_t due_res;

  parse_phase_t    ph = P_TYPE;
  bit              hdr_array = 1'b0;
  longint unsigned len_acc = 0;
  logic [31:0]     pay_left = '0;
  logic [31:0]     elems_left = '0;
  int unsigned     arg_cnt = 0;

  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int bad_count = 0;
  int bytes_in = 0;
  int results_seen = 0;
  int kind_seen[0:7] = '{default: 0};

  resp_request_parser #(
    .MAX_ARGS    (MAX_ARGS),
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .stream_byte    (stream_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .arg_index      (arg_index),
    .element_count  (element_count),
    .last_in_arg    (last_in_arg),
    .last_in_request(last_in_request)
  );

  always #2 clk = ~clk;

  function automatic void abort_request();
    elems_left = '0;
    arg_cnt = 0;
    len_acc = 0;
    ph = P_TYPE;
  endfunction

  function automatic void close_argument();
    if (elems_left > 0) elems_left = elems_left - 1;
    if (arg_cnt < MAX_ARGS) arg_cnt = arg_cnt + 1;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    bit              last_req;
    bit              last_pay;
    longint unsigned acc_next;
    r = '0;
    last_req = (elems_left <= 1);
    case (ph)
      P_TYPE: begin
        if (b == CH_STAR || b == CH_DOLLAR) begin
          hdr_array = (b == CH_STAR);
          len_acc = 0;
          ph = P_LEN;
        end
        return 1'b0;
      end
      P_LEN: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          acc_next = len_acc * 10 + longint'(b - CH_ZERO);
          if (acc_next > LEN_LIMIT) begin
            abort_request();
            r.kind = KIND_LEN_ERR;
            return 1'b1;
          end
          len_acc = acc_next;
          return 1'b0;
        end
        if (b != CH_CR) begin
          abort_request();
          r.kind = KIND_LEN_ERR;
          return 1'b1;
        end
        if (hdr_array) begin
          elems_left = len_acc[31:0];
          arg_cnt = 0;
          ph = P_LF;
          r.kind = KIND_START;
          r.element_count = len_acc[31:0];
          return 1'b1;
        end
        if (arg_cnt >= MAX_ARGS) begin
          r.kind = KIND_TOO_MANY;
          r.arg_index = arg_cnt[3:0];
          abort_request();
          return 1'b1;
        end
        pay_left = len_acc[31:0];
        ph = P_LF;
        if (pay_left == 0) begin
          r.kind = KIND_EMPTY;
          r.arg_index = arg_cnt[3:0];
          r.last_in_arg = 1'b1;
          r.last_in_request = last_req;
          close_argument();
          return 1'b1;
        end
        return 1'b0;
      end
      P_LF: begin
        if (hdr_array) ph = P_TYPE;
        else if (pay_left == 0) ph = P_TRAIL_CR;
        else ph = P_PAYLOAD;
        return 1'b0;
      end
      P_PAYLOAD: begin
        last_pay = (pay_left <= 1);
        r.kind = KIND_PAYLOAD;
        r.data_byte = b;
        r.arg_index = arg_cnt[3:0];
        r.last_in_arg = last_pay;
        r.last_in_request = last_req;
        if (last_pay) begin
          pay_left = '0;
          close_argument();
          ph = P_TRAIL_CR;
        end else begin
          pay_left = pay_left - 1;
        end
        return 1'b1;
      end
      P_TRAIL_CR: begin
        ph = P_TRAIL_LF;
        return 1'b0;
      end
      default: begin
        ph = P_TYPE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("kind=%0d data=%0d arg=%0d count=%0d last_arg=%0d last_req=%0d",
                     r.kind, r.data_byte, r.arg_index, r.element_count,
                     r.last_in_arg, r.last_in_request);
  endfunction

  task automatic put(input logic [7:0] v);
    feed_q.push_back('{OP_BYTE, v});
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) put(s[i]);
  endtask

  task automatic put_crlf();
    put(CH_CR);
    put(CH_LF);
  endtask

  task automatic put_head(input logic [7:0] mark, input longint unsigned n);
    put(mark);
    put_text($sformatf("%0d", n));
    put_crlf();
  endtask

  // wild_trail: the skipped bytes after the payload carry random values
  task automatic put_bulk(input int len, input bit wild_trail);
    put_head(CH_DOLLAR, len);
    repeat (len) put(8'($urandom_range(0, 255)));
    if (wild_trail) begin
      put(8'($urandom_range(0, 255)));
      put(8'($urandom_range(0, 255)));
    end else begin
      put_crlf();
    end
  endtask

  task automatic put_bad_header();
    logic [7:0] v;
    put($urandom_range(0, 1) ? CH_STAR : CH_DOLLAR);
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(0, 3)) put(CH_ZERO + 8'($urandom_range(0, 9)));
      do v = 8'($urandom_range(0, 255));
      while ((v >= CH_ZERO && v <= CH_NINE) || v == CH_CR);
      put(v);
    end else begin
      put(CH_ZERO + 8'($urandom_range(4, 9)));
      repeat ($urandom_range(9, 11)) put(CH_ZERO + 8'($urandom_range(0, 9)));
      put_crlf();
    end
  endtask

  task automatic put_request();
    int n;
    int cnt;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 4);
    cnt = n;
    case ($urandom_range(0, 19))
      0: cnt = n + 1;
      1: if (n > 0) cnt = n - 1;
      default: ;
    endcase
    put_head(CH_STAR, cnt);
    repeat (n)
      put_bulk(($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6),
               $urandom_range(0, 9) == 0);
  endtask

  task automatic build_stimulus();
    int pick;
    int mark;
    int counted;
    bit held;
    bit drained;
    counted = 0;
    held = 0;
    drained = 0;

    // data extremes
    put_head(CH_STAR, 1);
    put_head(CH_DOLLAR, 2);
    put(8'h00);
    put(8'hFF);
    put_crlf();
    // largest count, then an empty argument
    put_head(CH_STAR, LEN_LIMIT);
    put_bulk(0, 0);
    // CR right after the type byte
    put(CH_DOLLAR);
    put_crlf();
    put_crlf();
    // overflowing length, then a bad length byte
    put_text("*4294967296");
    put_crlf();
    put_text("$1x");
    // nested request with skipped bytes of any value
    put_head(CH_STAR, 3);
    put_bulk(1, 0);
    put_head(CH_STAR, 2);
    put_bulk(3, 1);
    put_bulk(1, 0);
    // stray argument and an empty request
    put_bulk(2, 0);
    put_head(CH_STAR, 0);
    // fill all argument slots, then overflow them
    put_head(CH_STAR, 17);
    repeat (MAX_ARGS) put_bulk(1, 0);
    put_head(CH_DOLLAR, 3);
    put_text("xyz");
    put_crlf();
    // noise at the type byte and leading zeros in a length
    put_text("+OK");
    put_crlf();
    put_text("$0003");
    put_crlf();
    put_text("abc");
    put_crlf();
    counted = feed_q.size();
    feed_q.push_back('{OP_DRAIN, 8'h00});

    while (counted < STREAM_BYTES) begin
      mark = feed_q.size();
      pick = $urandom_range(0, 99);
      if (!held && counted > 350) begin
        // long payload while the receiver holds off
        held = 1;
        feed_q.push_back('{OP_HOLD, 8'h00});
        put_head(CH_STAR, 1);
        put_bulk(40, 0);
      end else if (!drained && counted > 550) begin
        drained = 1;
        feed_q.push_back('{OP_DRAIN, 8'h00});
      end else if (pick < 60) begin
        put_request();
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 2)) put_bulk($urandom_range(0, 5), 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        put_bad_header();
      end else if (pick < 95) begin
        put_head(CH_STAR, ($urandom_range(0, 1)) ? $urandom() : $urandom_range(2, 5));
        put_bulk($urandom_range(0, 4), 0);
      end else begin
        put(CH_DOLLAR);
        repeat ($urandom_range(0, 3)) put(CH_ZERO);
        put_crlf();
        put_crlf();
      end
      counted += feed_q.size() - mark;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (feed_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (feed_q[0].op == OP_DRAIN) begin
        in_valid <= 1'b0;
        if (!in_valid && parsed_q.size() == 0) feed_q.delete(0);
      end else if (feed_q[0].op == OP_HOLD) begin
        in_valid <= 1'b0;
        hold_req <= hold_req + 1;
        feed_q.delete(0);
      end else if (feed_q.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b1;
        stream_byte <= feed_q[0].val;
        feed_q.delete(0);
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (feed_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // predict on input, check on output
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        bytes_in++;
        if (parse_byte(stream_byte, due_res)) parsed_q.push_back(due_res);
      end
      if (out_valid && out_ready) begin
        seen_res = {kind, data_byte, arg_index, element_count, last_in_arg, last_in_request};
        results_seen++;
        kind_seen[kind]++;
        if (parsed_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected result: %s", fmt_result(seen_res));
        end else begin
          due_res = parsed_q.pop_front();
          if (seen_res.kind !== due_res.kind || seen_res.data_byte !== due_res.data_byte ||
              seen_res.arg_index !== due_res.arg_index ||
              seen_res.element_count !== due_res.element_count ||
              seen_res.last_in_arg !== due_res.last_in_arg ||
              seen_res.last_in_request !== due_res.last_in_request) begin
            bad_count++;
            if (bad_count <= 10)
              $display("mismatch: expected %s, got %s",
                       fmt_result(due_res), fmt_result(seen_res));
          end
        end
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (feed_q.size() > 0 || in_valid) @(negedge clk);
    while (parsed_q.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("streamed %0d bytes, checked %0d results", bytes_in, results_seen);
    $display("payload %0d, starts %0d, empty args %0d, length errors %0d, arg overflows %0d",
             kind_seen[KIND_PAYLOAD], kind_seen[KIND_START], kind_seen[KIND_EMPTY],
             kind_seen[KIND_LEN_ERR], kind_seen[KIND_TOO_MANY]);
    if (bad_count == 0) begin
      $display("tb_resp_request_parser passed");
    end else begin
      $display("%0d mismatches", bad_count);
      $display("tb_resp_request_parser failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("tb_resp_request_parser failed");
    $finish;
  end

endmodule
